FILE: hw/rtl/area_average_image_minifier_unit_defines.svh
// Assertion macros for the area-average minifier checker.
// Expects aclk and aresetn in the scope of use.
`ifndef AREA_AVERAGE_IMAGE_MINIFIER_UNIT_DEFINES_SVH
`define AREA_AVERAGE_IMAGE_MINIFIER_UNIT_DEFINES_SVH

// antecedent implies consequent in the next cycle, outside reset
`define AAMI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aami: assertion failed");

// antecedent implies consequent after a delay, outside reset
`define AAMI_ASSERT_DLY2(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##2 (cons)) \
        else $error("aami: assertion failed");

// checked during reset as well
`define AAMI_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("aami: assertion failed");

`endif

FILE: hw/rtl/aami_pkg.sv
// Shared constants, types and register codes of the area-average minifier.
// No dependencies.
package aami_pkg;

    localparam int MAX_TARGET_SIDE = 1024;
    localparam int MAX_SOURCE_SIDE = 16384;
    localparam int SIDE_W     = 15;
    localparam int TSIDE_W    = 11;
    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int NCH        = 4;
    localparam int SUM_W      = 32;
    localparam int COL_W      = $clog2(MAX_TARGET_SIDE);
    localparam int ACC_AW     = COL_W + 1;
    localparam int ACC_DEPTH  = 2 * MAX_TARGET_SIDE;
    localparam int ACC_DW     = NCH * SUM_W;
    localparam int AREA_W     = 2 * SIDE_W;
    localparam int AREA_LIMIT = 1 << 23;
    localparam int DIV_W      = 24;
    localparam int SHIFT_W    = 3;
    localparam int WGT_W      = 2 * TSIDE_W;
    localparam int PROD_W     = CH_W + WGT_W;
    localparam int QREM_W     = SUM_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 4'd3;

    localparam logic [SIDE_W-1:0]  RST_SRC_W = 15'd300;
    localparam logic [SIDE_W-1:0]  RST_SRC_H = 15'd150;
    localparam logic [TSIDE_W-1:0] RST_TGT_W = 11'd1;
    localparam logic [TSIDE_W-1:0] RST_TGT_H = 11'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_ADV
    } state_t;

    typedef struct packed {
        logic              clr_we;
        logic [ACC_AW-1:0] clr_addr;
        logic              accept;
        logic              rd;
        logic              wr;
        logic              div_start;
        logic              adv;
        logic [1:0]        k;
    } cmd_t;

    typedef struct packed {
        logic       cfg_hit;
        logic       cfg_ok;
        logic [3:0] k_en;
        logic       emit;
        logic       div_busy;
    } status_t;

endpackage

FILE: hw/rtl/aami_div.sv
// Four-lane rounding divider with result register for finished target pixels.
// Depends on aami_pkg.
module aami_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [aami_pkg::NCH-1:0][aami_pkg::SUM_W-1:0] sums,
    input  logic [aami_pkg::DIV_W-1:0]             divisor,
    input  logic                                   last,
    output logic                                   busy,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [aami_pkg::PIX_W-1:0]             m_target_pixel,
    output logic                                   m_last_of_image
);
    import aami_pkg::*;

    logic [NCH-1:0][QREM_W-1:0] rem_reg, rem_next;
    logic [NCH-1:0][CH_W-1:0]   q_reg, q_next;
    logic [2:0]                 cnt_reg;
    logic                       run_reg, pend_reg, last_reg;
    logic [DIV_W-1:0]           div_reg;
    logic                       out_valid_reg;
    logic [PIX_W-1:0]           out_pix_reg;
    logic                       out_last_reg;
    logic [QREM_W-1:0]          dsh;
    logic                       xfer;

    assign dsh  = {{(QREM_W-DIV_W){1'b0}}, div_reg} << cnt_reg;
    assign xfer = pend_reg && (!out_valid_reg || m_ready);
    assign busy = run_reg || pend_reg;

    always_comb begin
        rem_next = rem_reg;
        q_next   = q_reg;
        for (int i = 0; i < NCH; i++) begin
            if (rem_reg[i] >= dsh) begin
                rem_next[i]        = rem_reg[i] - dsh;
                q_next[i][cnt_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (start) begin
                run_reg  <= 1'b1;
                cnt_reg  <= 3'd7;
                div_reg  <= divisor;
                last_reg <= last;
                for (int i = 0; i < NCH; i++) begin
                    rem_reg[i] <= {1'b0, sums[i]} +
                                  {{(QREM_W-DIV_W+1){1'b0}}, divisor[DIV_W-1:1]};
                    q_reg[i]   <= '0;
                end
            end else if (run_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    run_reg  <= 1'b0;
                    pend_reg <= 1'b1;
                end
            end
            if (xfer) begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                out_pix_reg   <= {q_reg[0], q_reg[1], q_reg[2], q_reg[3]};
                out_last_reg  <= last_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_target_pixel  = out_pix_reg;
    assign m_last_of_image = out_last_reg;

endmodule

FILE: hw/rtl/aami_ctrl.sv
// Sequencer: clearing pass, item accept, per-target read-modify-write steps.
// Depends on aami_pkg.
module aami_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aami_pkg::status_t sts,
    output aami_pkg::cmd_t    cmd
);
    import aami_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        k_reg, k_next;
    logic [ACC_AW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.k      = k_reg;
        cmd.clr_addr = cnt_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (&cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    k_next     = '0;
                    if (sts.cfg_ok) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                if (sts.k_en[k_reg]) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_WR;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_ADV;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_WR: begin
                if (!(k_reg == 2'd0 && sts.emit && sts.div_busy)) begin
                    cmd.wr        = 1'b1;
                    cmd.div_start = (k_reg == 2'd0) && sts.emit;
                    if (k_reg == 2'd3) begin
                        state_next = ST_ADV;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        if (sts.cfg_hit) begin
            state_next = ST_CLEAR;
            cnt_next   = '0;
        end
    end

endmodule

FILE: hw/rtl/aami_dp.sv
// Datapath: config registers, raster position, weights, accumulator memory.
// Depends on aami_pkg and aami_div.
module aami_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [aami_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aami_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [aami_pkg::PIX_W-1:0]       s_source_pixel,
    input  aami_pkg::cmd_t                   cmd,
    output aami_pkg::status_t                sts,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aami_pkg::PIX_W-1:0]       m_target_pixel,
    output logic                             m_last_of_image
);
    import aami_pkg::*;

    logic [SIDE_W-1:0]  sw_reg, sh_reg;
    logic [TSIDE_W-1:0] tw_reg, th_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [SHIFT_W-1:0] shift_reg, shift_c;
    logic [DIV_W-1:0]   divisor_reg;
    logic               cfg_hit, cfg_ok;

    logic [SIDE_W-1:0]  x_reg, y_reg, rx_reg, ry_reg;
    logic [TSIDE_W-1:0] tx_reg, ty_reg;

    logic [PIX_W-1:0]           pix_reg;
    logic [3:0][WGT_W-1:0]      w_reg;
    logic [3:0]                 k_en_reg;
    logic                       emit_reg, last_reg;

    logic [ACC_DW-1:0]          acc_mem [ACC_DEPTH];
    logic [ACC_DW-1:0]          rdata_reg;
    logic [NCH-1:0][PROD_W-1:0] prod_reg;

    logic [SIDE_W:0]    top_raw, lft_raw, rx_inc, ry_inc, x_inc, y_inc;
    logic [TSIDE_W-1:0] top_w, bot_w, lft_w, rgt_w;
    logic [3:0][WGT_W-1:0] w_c;
    logic               row_end, col_end;
    logic [TSIDE_W-1:0] col_k;
    logic [ACC_AW-1:0]  addr_k, waddr;
    logic [NCH-1:0][SUM_W-1:0] sums;
    logic [ACC_DW-1:0]  wdata;
    logic               we;

    assign cfg_hit = cfg_valid && (cfg_index == REG_SRC_W || cfg_index == REG_SRC_H ||
                                   cfg_index == REG_TGT_W || cfg_index == REG_TGT_H);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= RST_SRC_W;
            sh_reg <= RST_SRC_H;
            tw_reg <= RST_TGT_W;
            th_reg <= RST_TGT_H;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_W: sw_reg <= cfg_data[SIDE_W-1:0];
                REG_SRC_H: sh_reg <= cfg_data[SIDE_W-1:0];
                REG_TGT_W: tw_reg <= cfg_data[TSIDE_W-1:0];
                REG_TGT_H: th_reg <= cfg_data[TSIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ok = sw_reg != '0 && sh_reg != '0 && tw_reg != '0 && th_reg != '0 &&
                    {1'b0, sw_reg} <= (SIDE_W+1)'(MAX_SOURCE_SIDE) &&
                    {1'b0, sh_reg} <= (SIDE_W+1)'(MAX_SOURCE_SIDE) &&
                    {1'b0, tw_reg} <= (TSIDE_W+1)'(MAX_TARGET_SIDE) &&
                    {1'b0, th_reg} <= (TSIDE_W+1)'(MAX_TARGET_SIDE) &&
                    SIDE_W'(tw_reg) < sw_reg && SIDE_W'(th_reg) < sh_reg;

    // smallest shift bringing the source area to at most 2^23
    always_comb begin
        shift_c = '0;
        for (int s = 7; s >= 0; s--) begin
            if ((area_reg >> s) <= AREA_W'(AREA_LIMIT)) begin
                shift_c = SHIFT_W'(s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        area_reg    <= AREA_W'(sw_reg) * AREA_W'(sh_reg);
        shift_reg   <= shift_c;
        divisor_reg <= DIV_W'(area_reg >> shift_c);
    end

    // overlap weights for the current raster position
    assign top_raw = {1'b0, sh_reg} - {1'b0, ry_reg};
    assign lft_raw = {1'b0, sw_reg} - {1'b0, rx_reg};
    assign top_w   = (top_raw > (SIDE_W+1)'(th_reg)) ? th_reg : top_raw[TSIDE_W-1:0];
    assign lft_w   = (lft_raw > (SIDE_W+1)'(tw_reg)) ? tw_reg : lft_raw[TSIDE_W-1:0];
    assign bot_w   = th_reg - top_w;
    assign rgt_w   = tw_reg - lft_w;
    assign w_c[0]  = (WGT_W'(top_w) * WGT_W'(lft_w)) >> shift_reg;
    assign w_c[1]  = (WGT_W'(top_w) * WGT_W'(rgt_w)) >> shift_reg;
    assign w_c[2]  = (WGT_W'(bot_w) * WGT_W'(lft_w)) >> shift_reg;
    assign w_c[3]  = (WGT_W'(bot_w) * WGT_W'(rgt_w)) >> shift_reg;

    assign x_inc   = {1'b0, x_reg} + 1'b1;
    assign y_inc   = {1'b0, y_reg} + 1'b1;
    assign rx_inc  = {1'b0, rx_reg} + (SIDE_W+1)'(tw_reg);
    assign ry_inc  = {1'b0, ry_reg} + (SIDE_W+1)'(th_reg);
    assign row_end = (y_inc == {1'b0, sh_reg}) || (ry_inc >= {1'b0, sh_reg});
    assign col_end = (x_inc == {1'b0, sw_reg}) || (rx_inc >= {1'b0, sw_reg});

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg     <= s_source_pixel;
            w_reg       <= w_c;
            k_en_reg[0] <= 1'b1;
            k_en_reg[1] <= ({1'b0, tx_reg} + 1'b1) < {1'b0, tw_reg};
            k_en_reg[2] <= ({1'b0, ty_reg} + 1'b1) < {1'b0, th_reg};
            k_en_reg[3] <= (({1'b0, tx_reg} + 1'b1) < {1'b0, tw_reg}) &&
                           (({1'b0, ty_reg} + 1'b1) < {1'b0, th_reg});
            emit_reg    <= row_end && col_end;
            last_reg    <= (x_inc == {1'b0, sw_reg}) && (y_inc == {1'b0, sh_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            x_reg  <= '0;
            y_reg  <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
        end else if (cmd.adv) begin
            if (x_inc == {1'b0, sw_reg}) begin
                x_reg  <= '0;
                rx_reg <= '0;
                tx_reg <= '0;
                if (y_inc == {1'b0, sh_reg}) begin
                    y_reg  <= '0;
                    ry_reg <= '0;
                    ty_reg <= '0;
                end else begin
                    y_reg <= y_inc[SIDE_W-1:0];
                    if (ry_inc >= {1'b0, sh_reg}) begin
                        ry_reg <= SIDE_W'(ry_inc - {1'b0, sh_reg});
                        ty_reg <= ty_reg + 1'b1;
                    end else begin
                        ry_reg <= ry_inc[SIDE_W-1:0];
                    end
                end
            end else begin
                x_reg <= x_inc[SIDE_W-1:0];
                if (rx_inc >= {1'b0, sw_reg}) begin
                    rx_reg <= SIDE_W'(rx_inc - {1'b0, sw_reg});
                    tx_reg <= tx_reg + 1'b1;
                end else begin
                    rx_reg <= rx_inc[SIDE_W-1:0];
                end
            end
        end
    end

    // accumulator row address of target k: {target row parity, target column}
    assign col_k  = tx_reg + TSIDE_W'(cmd.k[0]);
    assign addr_k = {ty_reg[0] ^ cmd.k[1], col_k[COL_W-1:0]};

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            sums[i] = rdata_reg[i*SUM_W +: SUM_W] + SUM_W'(prod_reg[i]);
        end
    end

    assign we    = cmd.clr_we || cmd.wr;
    assign waddr = cmd.clr_we ? cmd.clr_addr : addr_k;
    assign wdata = (cmd.clr_we || (emit_reg && cmd.k == 2'd0)) ? '0 : ACC_DW'(sums);

    always_ff @(posedge aclk) begin
        if (we) begin
            acc_mem[waddr] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= acc_mem[addr_k];
            for (int i = 0; i < NCH; i++) begin
                prod_reg[i] <= PROD_W'(pix_reg[PIX_W-CH_W*(i+1) +: CH_W]) *
                               PROD_W'(w_reg[cmd.k]);
            end
        end
    end

    aami_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (cmd.div_start),
        .sums            (sums),
        .divisor         (divisor_reg),
        .last            (last_reg),
        .busy            (sts.div_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_pixel  (m_target_pixel),
        .m_last_of_image (m_last_of_image)
    );

    assign sts.cfg_hit = cfg_hit;
    assign sts.cfg_ok  = cfg_ok;
    assign sts.k_en    = k_en_reg;
    assign sts.emit    = emit_reg;

endmodule

FILE: hw/rtl/area_average_image_minifier_unit.sv
// Top level of the area-average image minifier: sequencer plus datapath.
// Depends on aami_pkg, aami_ctrl, aami_dp (and aami_div below it).
//
// channel  direction  handshake           payload
// s_       in         s_valid / s_ready   s_source_pixel
// m_       out        m_valid / m_ready   m_target_pixel, m_last_of_image
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Per source pixel: accept, an accumulator read and write for each overlapped target
// (single-port accumulator memory), a pass over each skipped target, then advance.
// With an invalid geometry a pixel is accepted and dropped. A finished target pixel
// takes 8 divide steps; the result then moves to the output register behind m_valid.
// After reset and after each register write a clearing pass over the 2048 accumulator
// entries runs, during which s_ready is low. A stalled output only stalls the next emit.
module area_average_image_minifier_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [aami_pkg::PIX_W-1:0]      s_source_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [aami_pkg::PIX_W-1:0]      m_target_pixel,
    output logic                            m_last_of_image,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aami_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aami_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aami_pkg::*;

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    aami_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aami_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_source_pixel  (s_source_pixel),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_pixel  (m_target_pixel),
        .m_last_of_image (m_last_of_image)
    );

endmodule

FILE: hw/rtl/aami_chk.sv
// Port-level checker for the area-average minifier, bound to the top level.
// Depends on aami_pkg and the defines header.
`include "area_average_image_minifier_unit_defines.svh"

module aami_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [aami_pkg::CFG_IDX_W-1:0]  cfg_index
);
    import aami_pkg::*;

    `AAMI_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !s_ready && !m_valid)
    `AAMI_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready && cfg_index <= REG_TGT_H, !s_ready)
    `AAMI_ASSERT_DLY2(a_cfg_clear_len, cfg_valid && cfg_ready && cfg_index <= REG_TGT_H, !s_ready)
    `AAMI_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid)

endmodule

bind area_average_image_minifier_unit aami_chk u_aami_chk (.*);
